// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/pdi_pkg.sv
`default_nettype none

package pdi_pkg;

   localparam int PRICE_BITS    = 32;
   localparam int ACC_BITS      = 48;
   localparam int DI_BITS       = 23;
   localparam int PERIOD_BITS   = 11;
   localparam int UNSTABLE_BITS = 12;
   localparam int BARS_BITS     = 13;
   localparam int STEP_BITS     = 6;
   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [DI_BITS-1:0]       DI_FULL        = 23'd6553600;
   localparam logic [PERIOD_BITS-1:0]   PERIOD_RESET   = 11'd14;
   localparam logic [UNSTABLE_BITS-1:0] UNSTABLE_RESET = 12'd0;
   localparam logic [STEP_BITS-1:0]     DIV_LAST_STEP  = 6'(ACC_BITS - 1);
   localparam logic [STEP_BITS-1:0]     RATIO_TOP_BIT  = 6'(DI_BITS - 1);

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNSTABLE = 1'd1;

   // Control of the shared divide step.
   typedef struct packed {
      logic add_op;    // add the numerator instead of doubling
      logic shift_in;  // bit shifted into the remainder on a doubling step
   } step_ctl_type;

   // Per-bar differences against the previous bar, plus high minus low of the bar.
   typedef struct packed {
      logic [PRICE_BITS-1:0]        move;
      logic signed [PRICE_BITS:0]   high_low;
      logic [PRICE_BITS-1:0]        high_close;
      logic [PRICE_BITS-1:0]        low_close;
   } delta_type;

endpackage

`default_nettype wire

// File: sv/pdi_req_if.sv
`default_nettype none

interface pdi_req_if;
   logic                            valid;
   logic                            ready;
   logic [pdi_pkg::PRICE_BITS-1:0]  high_price;
   logic [pdi_pkg::PRICE_BITS-1:0]  low_price;
   logic [pdi_pkg::PRICE_BITS-1:0]  close_price;
   logic                            first_bar;

   modport source (output valid, output high_price, output low_price,
                   output close_price, output first_bar, input ready);
   modport sink   (input valid, input high_price, input low_price,
                   input close_price, input first_bar, output ready);
endinterface

`default_nettype wire

// File: sv/pdi_rsp_if.sv
`default_nettype none

interface pdi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pdi_pkg::DI_BITS-1:0]  plus_di;

   modport source (output valid, output plus_di, input ready);
   modport sink   (input valid, input plus_di, output ready);
endinterface

`default_nettype wire

// File: sv/pdi_bar_delta.sv
`default_nettype none

module pdi_bar_delta (
   input  wire logic [pdi_pkg::PRICE_BITS-1:0] high_price,
   input  wire logic [pdi_pkg::PRICE_BITS-1:0] low_price,
   input  wire logic [pdi_pkg::PRICE_BITS-1:0] last_high,
   input  wire logic [pdi_pkg::PRICE_BITS-1:0] last_low,
   input  wire logic [pdi_pkg::PRICE_BITS-1:0] last_close,
   output pdi_pkg::delta_type                  delta
);

   logic signed [pdi_pkg::PRICE_BITS:0] up_move;
   logic signed [pdi_pkg::PRICE_BITS:0] down_move;

   always_comb begin
      up_move   = $signed({1'b0, high_price}) - $signed({1'b0, last_high});
      down_move = $signed({1'b0, last_low}) - $signed({1'b0, low_price});

      // Count the up move only when positive and above the down move.
      if ((up_move > 0) && (up_move > down_move)) begin
         delta.move = up_move[pdi_pkg::PRICE_BITS-1:0];
      end else begin
         delta.move = '0;
      end

      delta.high_low = $signed({1'b0, high_price}) - $signed({1'b0, low_price});

      if (high_price >= last_close) begin
         delta.high_close = high_price - last_close;
      end else begin
         delta.high_close = last_close - high_price;
      end

      if (low_price >= last_close) begin
         delta.low_close = low_price - last_close;
      end else begin
         delta.low_close = last_close - low_price;
      end
   end

endmodule

`default_nettype wire

// File: sv/pdi_step_unit.sv
`default_nettype none

// One restoring step: form the trial remainder by doubling (with a shifted-in
// bit) or by adding the numerator, then subtract the divisor if it fits.
module pdi_step_unit (
   input  wire pdi_pkg::step_ctl_type            ctl,
   input  wire logic [pdi_pkg::ACC_BITS-1:0]     rem,
   input  wire logic [pdi_pkg::ACC_BITS-1:0]     addend,
   input  wire logic [pdi_pkg::ACC_BITS-1:0]     divisor,
   output logic      [pdi_pkg::ACC_BITS-1:0]     rem_next,
   output logic                                  qbit
);

   logic [pdi_pkg::ACC_BITS:0]   trial;
   logic [pdi_pkg::ACC_BITS+1:0] diff;

   always_comb begin
      if (ctl.add_op) begin
         trial = {1'b0, rem} + {1'b0, addend};
      end else begin
         trial = {rem, ctl.shift_in};
      end
      diff     = {1'b0, trial} - {2'b00, divisor};
      qbit     = ~diff[pdi_pkg::ACC_BITS+1];
      rem_next = qbit ? diff[pdi_pkg::ACC_BITS-1:0] : trial[pdi_pkg::ACC_BITS-1:0];
   end

endmodule

`default_nettype wire

// File: sv/plus_directional_indicator_core.sv
`default_nettype none

`include "assert_macros.svh"

// Plus directional indicator (+DI) with Wilder smoothing, one price bar per
// request. A bar compares with the previous bar; the first bar of a series
// (first_bar set, or the first bar after reset) only loads history and
// gives no result. With period 0 or 1 every later bar gives
// 100 * move / range. With period N the moves and true ranges of bars
// 1..N-1 are summed; from bar N on both sums are smoothed as x - x/N + new
// (saturating at 48 bits) and bar N + unstable_bars and later give
// 100 * sum_move / sum_range in unsigned Q7.16 (zero range gives 0).
// One request is worked at a time; req.ready is low while busy. A series
// start only loads history, a summing bar adds to both sums, a period-one
// bar runs the 26-step ratio and a smoothing bar two 48-step divisions by
// N plus the ratio when due, all on one shared restoring divide-step unit.
// The result sits in an output register; a new request is taken while it
// waits; the block holds its next result until the previous one is taken.
// Configuration writes land at once and must only be made while idle.
module plus_directional_indicator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   pdi_req_if.sink                                   req,
   pdi_rsp_if.source                                 rsp,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pdi_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [pdi_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIFF   = 4'd1;
   localparam logic [3:0] S_RANGE  = 4'd2;
   localparam logic [3:0] S_ACCUM  = 4'd3;
   localparam logic [3:0] S_DIVM   = 4'd4;
   localparam logic [3:0] S_SUBM   = 4'd5;
   localparam logic [3:0] S_DIVR   = 4'd6;
   localparam logic [3:0] S_SUBR   = 4'd7;
   localparam logic [3:0] S_SMOOTH = 4'd8;
   localparam logic [3:0] S_RSET   = 4'd9;
   localparam logic [3:0] S_RATIO  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   localparam int PB = pdi_pkg::PRICE_BITS;
   localparam int AB = pdi_pkg::ACC_BITS;

   // Control state.
   logic [3:0]                           state_ff, state_in;
   logic [pdi_pkg::PERIOD_BITS-1:0]      period_ff, period_in;
   logic [pdi_pkg::UNSTABLE_BITS-1:0]    unstable_ff, unstable_in;
   logic [pdi_pkg::BARS_BITS-1:0]        bars_seen_ff, bars_seen_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   // Datapath.
   logic [PB-1:0]                        in_high_ff, in_high_in;
   logic [PB-1:0]                        in_low_ff, in_low_in;
   logic [PB-1:0]                        in_close_ff, in_close_in;
   logic                                 in_first_ff, in_first_in;
   logic [PB-1:0]                        last_high_ff, last_high_in;
   logic [PB-1:0]                        last_low_ff, last_low_in;
   logic [PB-1:0]                        last_close_ff, last_close_in;
   logic [AB-1:0]                        sum_move_ff, sum_move_in;
   logic [AB-1:0]                        sum_range_ff, sum_range_in;
   pdi_pkg::delta_type                   delta_ff, delta_in;
   logic [PB-1:0]                        range_ff, range_in;
   logic                                 out_en_ff, out_en_in;
   logic [AB-1:0]                        rem_ff, rem_in;
   logic [AB-1:0]                        quo_ff, quo_in;
   logic [AB-1:0]                        den_ff, den_in;
   logic [AB-1:0]                        num_ff, num_in;
   logic [pdi_pkg::STEP_BITS-1:0]        step_ff, step_in;
   logic                                 add_phase_ff, add_phase_in;
   logic                                 res_zero_ff, res_zero_in;
   logic                                 res_full_ff, res_full_in;
   logic [pdi_pkg::DI_BITS-1:0]          rsp_di_ff, rsp_di_in;

   // Derived config.
   logic                                 single;
   logic [pdi_pkg::PERIOD_BITS-1:0]      n_eff;
   logic [pdi_pkg::BARS_BITS-1:0]        warm;
   logic [pdi_pkg::BARS_BITS:0]          bars_next;
   logic [PB-1:0]                        abs_max;

   pdi_pkg::delta_type                   delta_now;
   pdi_pkg::step_ctl_type                step_ctl;
   logic [AB-1:0]                        step_rem;
   logic                                 step_qbit;

   function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] x,
                                             input logic [PB-1:0] v);
      logic [AB:0] s;
      s = {1'b0, x} + {{(AB + 1 - PB){1'b0}}, v};
      return s[AB] ? {AB{1'b1}} : s[AB-1:0];
   endfunction

   pdi_bar_delta u_delta (
      .high_price (in_high_ff),
      .low_price  (in_low_ff),
      .last_high  (last_high_ff),
      .last_low   (last_low_ff),
      .last_close (last_close_ff),
      .delta      (delta_now)
   );

   pdi_step_unit u_step (
      .ctl      (step_ctl),
      .rem      (rem_ff),
      .addend   (num_ff),
      .divisor  (den_ff),
      .rem_next (step_rem),
      .qbit     (step_qbit)
   );

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.plus_di = rsp_di_ff;

   always_comb begin
      single    = (period_ff <= 11'd1);
      n_eff     = single ? 11'd1 : period_ff;
      warm      = single ? 13'd1 : ({2'b00, n_eff} + {1'b0, unstable_ff});
      bars_next = {1'b0, bars_seen_ff} + 14'd1;
      abs_max   = (delta_ff.high_close >= delta_ff.low_close) ?
                  delta_ff.high_close : delta_ff.low_close;
      // Ratio add steps add the numerator; divisions shift the dividend in.
      step_ctl.add_op   = (state_ff == S_RATIO) && add_phase_ff;
      step_ctl.shift_in = (state_ff == S_RATIO) ? 1'b0 : quo_ff[AB-1];
   end

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      unstable_in   = unstable_ff;
      bars_seen_in  = bars_seen_ff;
      rsp_valid_in  = rsp_valid_ff;
      in_high_in    = in_high_ff;
      in_low_in     = in_low_ff;
      in_close_in   = in_close_ff;
      in_first_in   = in_first_ff;
      last_high_in  = last_high_ff;
      last_low_in   = last_low_ff;
      last_close_in = last_close_ff;
      sum_move_in   = sum_move_ff;
      sum_range_in  = sum_range_ff;
      delta_in      = delta_ff;
      range_in      = range_ff;
      out_en_in     = out_en_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      step_in       = step_ff;
      add_phase_in  = add_phase_ff;
      res_zero_in   = res_zero_ff;
      res_full_in   = res_full_ff;
      rsp_di_in     = rsp_di_ff;

      // Drop the output once taken.
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; an unknown index is ignored.
      if (csr_write_enable) begin
         unique case (csr_index)
            pdi_pkg::CSR_PERIOD:
               period_in = csr_write_data[pdi_pkg::PERIOD_BITS-1:0];
            pdi_pkg::CSR_UNSTABLE:
               unstable_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               in_high_in  = req.high_price;
               in_low_in   = req.low_price;
               in_close_in = req.close_price;
               in_first_in = req.first_bar;
               state_in    = S_DIFF;
            end
         end

         S_DIFF: begin
            if (in_first_ff || (bars_seen_ff == '0)) begin
               // Series start: load history, clear the sums.
               last_high_in  = in_high_ff;
               last_low_in   = in_low_ff;
               last_close_in = in_close_ff;
               sum_move_in   = '0;
               sum_range_in  = '0;
               bars_seen_in  = 13'd1;
               state_in      = S_IDLE;
            end else begin
               delta_in = delta_now;
               state_in = S_RANGE;
            end
         end

         S_RANGE: begin
            // True range: a negative high-low loses to the absolute terms.
            if (!delta_ff.high_low[PB] && (delta_ff.high_low[PB-1:0] > abs_max)) begin
               range_in = delta_ff.high_low[PB-1:0];
            end else begin
               range_in = abs_max;
            end
            last_high_in  = in_high_ff;
            last_low_in   = in_low_ff;
            last_close_in = in_close_ff;
            bars_seen_in  = (bars_next > {1'b0, warm}) ? warm :
                            bars_next[pdi_pkg::BARS_BITS-1:0];
            out_en_in     = single || ((bars_seen_ff >= {2'b00, n_eff}) &&
                                       (bars_seen_ff >= warm));
            rem_in        = '0;
            quo_in        = sum_move_ff;
            den_in        = {{(AB - pdi_pkg::PERIOD_BITS){1'b0}}, n_eff};
            step_in       = '0;
            priority if (single) begin
               state_in = S_RSET;
            end else if (bars_seen_ff < {2'b00, n_eff}) begin
               state_in = S_ACCUM;
            end else begin
               state_in = S_DIVM;
            end
         end

         S_ACCUM: begin
            sum_move_in  = sat_add(sum_move_ff, delta_ff.move);
            sum_range_in = sat_add(sum_range_ff, range_ff);
            state_in     = S_IDLE;
         end

         S_DIVM, S_DIVR: begin
            rem_in  = step_rem;
            quo_in  = {quo_ff[AB-2:0], step_qbit};
            step_in = step_ff + 6'd1;
            if (step_ff == pdi_pkg::DIV_LAST_STEP) begin
               state_in = (state_ff == S_DIVM) ? S_SUBM : S_SUBR;
            end
         end

         S_SUBM: begin
            sum_move_in = sum_move_ff - quo_ff;
            rem_in      = '0;
            quo_in      = sum_range_ff;
            step_in     = '0;
            state_in    = S_DIVR;
         end

         S_SUBR: begin
            sum_range_in = sum_range_ff - quo_ff;
            state_in     = S_SMOOTH;
         end

         S_SMOOTH: begin
            sum_move_in  = sat_add(sum_move_ff, delta_ff.move);
            sum_range_in = sat_add(sum_range_ff, range_ff);
            state_in     = out_en_ff ? S_RSET : S_IDLE;
         end

         S_RSET: begin
            if (single) begin
               num_in = {{(AB - PB){1'b0}}, delta_ff.move};
               den_in = {{(AB - PB){1'b0}}, range_ff};
            end else begin
               num_in = sum_move_ff;
               den_in = sum_range_ff;
            end
            res_zero_in  = (den_in == '0);
            res_full_in  = (num_in >= den_in);
            rem_in       = '0;
            quo_in       = '0;
            step_in      = pdi_pkg::RATIO_TOP_BIT;
            add_phase_in = 1'b0;
            state_in     = (res_zero_in || res_full_in) ? S_DONE : S_RATIO;
         end

         S_RATIO: begin
            // Walk the scale constant MSB first: double, then add the
            // numerator where the constant has a one.
            rem_in = step_rem;
            if (add_phase_ff) begin
               quo_in       = quo_ff + {{(AB - 1){1'b0}}, step_qbit};
               add_phase_in = 1'b0;
            end else begin
               quo_in = {quo_ff[AB-2:0], step_qbit};
            end
            if (!add_phase_ff && pdi_pkg::DI_FULL[step_ff[4:0]]) begin
               add_phase_in = 1'b1;
            end else if (step_ff == '0) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff - 6'd1;
            end
         end

         S_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               priority if (res_zero_ff) begin
                  rsp_di_in = '0;
               end else if (res_full_ff) begin
                  rsp_di_in = pdi_pkg::DI_FULL;
               end else begin
                  rsp_di_in = quo_ff[pdi_pkg::DI_BITS-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= pdi_pkg::PERIOD_RESET;
         unstable_ff  <= pdi_pkg::UNSTABLE_RESET;
         bars_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         unstable_ff  <= unstable_in;
         bars_seen_ff <= bars_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_high_ff    <= in_high_in;
      in_low_ff     <= in_low_in;
      in_close_ff   <= in_close_in;
      in_first_ff   <= in_first_in;
      last_high_ff  <= last_high_in;
      last_low_ff   <= last_low_in;
      last_close_ff <= last_close_in;
      sum_move_ff   <= sum_move_in;
      sum_range_ff  <= sum_range_in;
      delta_ff      <= delta_in;
      range_ff      <= range_in;
      out_en_ff     <= out_en_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      step_ff       <= step_in;
      add_phase_ff  <= add_phase_in;
      res_zero_ff   <= res_zero_in;
      res_full_ff   <= res_full_in;
      rsp_di_ff     <= rsp_di_in;
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready, "request accepted but block still ready")
   `ASSERT_IMPLIES(a_rem_below_den, clock, reset, (state_ff == S_DIVM) || (state_ff == S_DIVR) || (state_ff == S_RATIO), rem_ff < den_ff, "divide remainder not below divisor")
   `ASSERT_IMPLIES(a_di_in_range, clock, reset, rsp_valid_ff, rsp_di_ff <= pdi_pkg::DI_FULL, "plus_di above full scale")

endmodule

`default_nettype wire

// File: tb/tb_plus_directional_indicator_core.sv
`default_nettype none

module tb_plus_directional_indicator_core;
   timeunit 1ns;
   timeprecision 1ps;

   // Watchdog limit on cycles without any request or result moving. The slowest
   // legitimate gap is a smoothing bar behind the long hold-off on the result
   // side, or the settle pause before a register write.
   localparam int QUIET_LIMIT   = 5000;
   // Cycles to let pass before a register write, once no result is pending. A
   // bar that gives no result may still be in the divider at that point.
   localparam int SETTLE_CYCLES = 200;
   // Length of the long result-side hold-off that backs up the request side.
   localparam int HOLD_CYCLES   = 600;
   localparam int SKIP_PERCENT  = 37;

   typedef struct packed {
      logic [pdi_pkg::PRICE_BITS-1:0] high_price;
      logic [pdi_pkg::PRICE_BITS-1:0] low_price;
      logic [pdi_pkg::PRICE_BITS-1:0] close_price;
      logic                           first_bar;
   } price_bar_type;

   // How a stimulus row is handled: checked against the predictor, typed in as
   // giving no result, typed in with a known value, or a register write.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_VALUE,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      price_bar_type                     bar;
      logic [pdi_pkg::DI_BITS-1:0]       di;
      logic [pdi_pkg::CSR_IDX_BITS-1:0]  csr_index;
      logic [pdi_pkg::CSR_DATA_BITS-1:0] csr_data;
   } stim_row_type;

   typedef struct packed {
      logic [pdi_pkg::CSR_DATA_BITS-1:0] period_data;
      logic [pdi_pkg::CSR_DATA_BITS-1:0] unstable_data;
      logic [9:0]                        bars;
      logic                              gaps;
      logic                              hold;
   } phase_type;

   localparam price_bar_type NO_BAR = '0;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASES = 9;

   // Directed part. Prices are raw Q16.16 codes; small ones keep the typed
   // results easy to check by hand.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // First bar after reset only loads history, even without first_bar.
      '{ROW_SILENT,  '{32'd10, 32'd5, 32'd7, 1'b0},       23'd0,   pdi_pkg::CSR_PERIOD, 12'd0},
      // Reset period is 14: still summing.
      '{ROW_SILENT,  '{32'd12, 32'd6, 32'd8, 1'b0},       23'd0,   pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_WRITE,   NO_BAR,                              23'd0,   pdi_pkg::CSR_PERIOD, 12'd1},
      '{ROW_SILENT,  '{32'd100, 32'd100, 32'd100, 1'b1},  23'd0,   pdi_pkg::CSR_PERIOD, 12'd0},
      // Zero true range gives zero.
      '{ROW_VALUE,   '{32'd100, 32'd100, 32'd100, 1'b0},  23'd0,   pdi_pkg::CSR_PERIOD, 12'd0},
      // Move equal to range hits full scale.
      '{ROW_VALUE,   '{32'd200, 32'd100, 32'd150, 1'b0},  pdi_pkg::DI_FULL,
        pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0}, 23'd0,
        pdi_pkg::CSR_PERIOD, 12'd0},
      // Inverted bar: high below low, up move is negative.
      '{ROW_VALUE,   '{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0}, 23'd0,  pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_VALUE,   '{32'd0, 32'd0, 32'd0, 1'b0},         23'd0,  pdi_pkg::CSR_PERIOD, 12'd0},
      // Restart with a close above the high, then a move larger than range.
      '{ROW_SILENT,  '{32'd0, 32'd0, 32'd100, 1'b1},       23'd0,  pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_VALUE,   '{32'd101, 32'd101, 32'd101, 1'b0},   pdi_pkg::DI_FULL,
        pdi_pkg::CSR_PERIOD, 12'd0},
      // Down move larger than up move: plus move drops to zero.
      '{ROW_VALUE,   '{32'd150, 32'd50, 32'd100, 1'b0},    23'd0,  pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_VALUE,   '{32'd200, 32'd100, 32'd100, 1'b0},   23'd3276800,
        pdi_pkg::CSR_PERIOD, 12'd0},
      // Period zero behaves as period one.
      '{ROW_WRITE,   NO_BAR,                               23'd0,  pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_VALUE,   '{32'd300, 32'd200, 32'd250, 1'b0},   23'd3276800,
        pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_WRITE,   NO_BAR,                               23'd0,  pdi_pkg::CSR_PERIOD, 12'd2},
      '{ROW_SILENT,  '{32'd1000, 32'd900, 32'd950, 1'b1},  23'd0,  pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'd1100, 32'd1000, 32'd1050, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'd1150, 32'd1080, 32'd1100, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'd1120, 32'd1000, 32'd1010, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0},
      // Extra warm-up bars mid-series: results pause until the new bound.
      '{ROW_WRITE,   NO_BAR,                               23'd0,  pdi_pkg::CSR_UNSTABLE, 12'd3},
      '{ROW_PREDICT, '{32'd1200, 32'd1100, 32'd1180, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'd1300, 32'd1190, 32'd1250, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'd1290, 32'd1200, 32'd1210, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0},
      '{ROW_PREDICT, '{32'd1400, 32'd1250, 32'd1390, 1'b0}, 23'd0, pdi_pkg::CSR_PERIOD, 12'd0}
   };

   // Random phases. Series carry over from phase to phase unless a bar sets
   // first_bar, so each write also lands mid-series. Period data with bit 11
   // set checks that the top bit is dropped.
   phase_type random_phases [PHASES] = '{
      '{12'h801, 12'h000, 10'd60,  1'b1, 1'b1},
      '{12'h800, 12'h555, 10'd20,  1'b1, 1'b0},
      '{12'h00E, 12'h000, 10'd80,  1'b1, 1'b0},
      '{12'h002, 12'hFFF, 10'd30,  1'b1, 1'b0},
      '{12'h003, 12'h005, 10'd60,  1'b1, 1'b0},
      '{12'h7FF, 12'h000, 10'd30,  1'b1, 1'b0},
      '{12'h040, 12'h000, 10'd100, 1'b1, 1'b0},
      '{12'h805, 12'h002, 10'd80,  1'b0, 1'b0},
      '{12'h001, 12'hFFF, 10'd40,  1'b1, 1'b0}
   };

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [pdi_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [pdi_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   pdi_req_if bar_if ();
   pdi_rsp_if di_if ();

   plus_directional_indicator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (bar_if),
      .rsp              (di_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: configuration and the running series.
   logic [pdi_pkg::PERIOD_BITS-1:0]   cfg_period;
   logic [pdi_pkg::UNSTABLE_BITS-1:0] cfg_unstable;
   logic [pdi_pkg::PRICE_BITS-1:0]    prev_high;
   logic [pdi_pkg::PRICE_BITS-1:0]    prev_low;
   logic [pdi_pkg::PRICE_BITS-1:0]    prev_close;
   logic [pdi_pkg::ACC_BITS-1:0]      sum_move;
   logic [pdi_pkg::ACC_BITS-1:0]      sum_range;
   logic [pdi_pkg::BARS_BITS-1:0]     bar_count;

   logic [pdi_pkg::DI_BITS-1:0] di_expected [$];
   int mismatch_count;
   int quiet_cycles;
   bit gaps_on;
   bit stall_request;
   longint walk_base;
   longint walk_spread;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Saturating add at accumulator width.
   function automatic logic [pdi_pkg::ACC_BITS-1:0] sat_sum(
         input logic [pdi_pkg::ACC_BITS-1:0] acc,
         input logic [pdi_pkg::ACC_BITS-1:0] add);
      logic [pdi_pkg::ACC_BITS:0] total;
      total = {1'b0, acc} + {1'b0, add};
      return total[pdi_pkg::ACC_BITS] ? '1 : total[pdi_pkg::ACC_BITS-1:0];
   endfunction

   // 100 * part / whole in unsigned Q7.16, truncated; 0 when whole is zero, else full scale when part >= whole.
   function automatic logic [pdi_pkg::DI_BITS-1:0] scale_ratio(
         input logic [pdi_pkg::ACC_BITS-1:0] part,
         input logic [pdi_pkg::ACC_BITS-1:0] whole);
      logic [127:0] wide;
      if (whole == '0) return '0;
      if (part >= whole) return pdi_pkg::DI_FULL;
      wide = (128'(part) * 128'(pdi_pkg::DI_FULL)) / 128'(whole);
      return wide[pdi_pkg::DI_BITS-1:0];
   endfunction

   // Advance the series by one bar; return 1 and the +DI value when the bar
   // gives a result.
   function automatic bit predict_plus_di(input price_bar_type b,
                                          output logic [pdi_pkg::DI_BITS-1:0] di);
      int unsigned span;
      int unsigned warm;
      int unsigned idx;
      longint up;
      longint down;
      longint move;
      longint range_hl;
      longint range_hc;
      longint range_lc;
      longint range_tr;
      bit hit;
      hit = 1'b0;
      di = '0;
      span = (cfg_period <= 1) ? 1 : cfg_period;
      warm = (span <= 1) ? 1 : span + cfg_unstable;
      if (b.first_bar || bar_count == '0) begin
         prev_high = b.high_price;
         prev_low = b.low_price;
         prev_close = b.close_price;
         sum_move = '0;
         sum_range = '0;
         bar_count = 13'd1;
         return 1'b0;
      end
      idx = bar_count;

      up = longint'(b.high_price) - longint'(prev_high);
      down = longint'(prev_low) - longint'(b.low_price);
      move = (up > 0 && up > down) ? up : 0;

      // True range; an inverted bar makes high - low negative.
      range_hl = longint'(b.high_price) - longint'(b.low_price);
      range_hc = longint'(b.high_price) - longint'(prev_close);
      range_lc = longint'(b.low_price) - longint'(prev_close);
      if (range_hc < 0) range_hc = -range_hc;
      if (range_lc < 0) range_lc = -range_lc;
      range_tr = range_hl;
      if (range_hc > range_tr) range_tr = range_hc;
      if (range_lc > range_tr) range_tr = range_lc;

      if (span == 1) begin
         di = scale_ratio(pdi_pkg::ACC_BITS'(move), pdi_pkg::ACC_BITS'(range_tr));
         hit = 1'b1;
      end else if (idx < span) begin
         sum_move = sat_sum(sum_move, pdi_pkg::ACC_BITS'(move));
         sum_range = sat_sum(sum_range, pdi_pkg::ACC_BITS'(range_tr));
      end else begin
         sum_move = sat_sum(sum_move - sum_move / span, pdi_pkg::ACC_BITS'(move));
         sum_range = sat_sum(sum_range - sum_range / span, pdi_pkg::ACC_BITS'(range_tr));
         if (idx >= warm) begin
            di = scale_ratio(sum_move, sum_range);
            hit = 1'b1;
         end
      end

      prev_high = b.high_price;
      prev_low = b.low_price;
      prev_close = b.close_price;
      bar_count = pdi_pkg::BARS_BITS'((idx + 1 > warm) ? warm : idx + 1);
      return hit;
   endfunction

   function automatic longint clamp_price(input longint v);
      if (v < 0) return 0;
      if (v > longint'(32'hFFFF_FFFF)) return longint'(32'hFFFF_FFFF);
      return v;
   endfunction

   // Mostly a random walk of well-formed bars (low <= close <= high), some flat
   // bars, some fully random noise and an occasional series restart.
   function automatic price_bar_type next_bar();
      price_bar_type b;
      longint top;
      longint bot;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         b.high_price = $urandom;
         b.low_price = $urandom;
         b.close_price = $urandom;
      end else begin
         walk_base = clamp_price(walk_base + longint'($urandom_range(0, 2 * walk_spread))
                                 - walk_spread);
         top = clamp_price(walk_base + longint'($urandom_range(0, walk_spread)));
         bot = clamp_price(walk_base - longint'($urandom_range(0, walk_spread)));
         if (pick < 16) begin
            top = walk_base;
            bot = walk_base;
         end
         b.high_price = top[pdi_pkg::PRICE_BITS-1:0];
         b.low_price = bot[pdi_pkg::PRICE_BITS-1:0];
         b.close_price = pdi_pkg::PRICE_BITS'(bot + longint'($urandom_range(0, top - bot)));
      end
      b.first_bar = ($urandom_range(0, 99) < 3);
      return b;
   endfunction

   // Offer one request, hold it until accepted, then record what it should give.
   // Leave valid high on return so back-to-back requests need no extra edge.
   task automatic send_bar(input price_bar_type b, input row_kind_type kind,
                           input logic [pdi_pkg::DI_BITS-1:0] typed_di);
      logic [pdi_pkg::DI_BITS-1:0] di;
      bit hit;
      while (gaps_on && $urandom_range(0, 99) < SKIP_PERCENT) begin
         bar_if.valid = 1'b0;
         @(negedge clock);
      end
      bar_if.valid = 1'b1;
      bar_if.high_price = b.high_price;
      bar_if.low_price = b.low_price;
      bar_if.close_price = b.close_price;
      bar_if.first_bar = b.first_bar;
      @(posedge clock);
      while (!bar_if.ready) @(posedge clock);
      hit = predict_plus_di(b, di);
      case (kind)
         ROW_VALUE:   di_expected.push_back(typed_di);
         ROW_PREDICT: if (hit) di_expected.push_back(di);
         default:     ;
      endcase
      @(negedge clock);
   endtask

   // Write a register once the block has drained. Drop valid first so the last
   // request is not taken twice, then give the divider time to finish a bar
   // that gives no result.
   task automatic write_register(input logic [pdi_pkg::CSR_IDX_BITS-1:0] index,
                                 input logic [pdi_pkg::CSR_DATA_BITS-1:0] data);
      bar_if.valid = 1'b0;
      while (di_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      case (index)
         pdi_pkg::CSR_PERIOD:   cfg_period = data[pdi_pkg::PERIOD_BITS-1:0];
         pdi_pkg::CSR_UNSTABLE: cfg_unstable = data[pdi_pkg::UNSTABLE_BITS-1:0];
         default:      ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic log_mismatch(input string what, input logic [pdi_pkg::DI_BITS-1:0] want,
                               input logic [pdi_pkg::DI_BITS-1:0] got);
      if (mismatch_count < 10)
         $display("%0t: %s: expected plus_di %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Result side: random idling, plus one long hold-off on request.
   initial begin
      di_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            // Hold off long enough for the block to fill and stall its input.
            di_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_request = 1'b0;
         end else begin
            di_if.ready = !(gaps_on && $urandom_range(0, 99) < SKIP_PERCENT);
         end
      end
   end

   // Check every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && di_if.valid && di_if.ready) begin
         if (di_expected.size() == 0)
            log_mismatch("result with none pending", '0, di_if.plus_di);
         else if (di_if.plus_di !== di_expected[0])
            log_mismatch("wrong result", di_expected.pop_front(), di_if.plus_di);
         else
            void'(di_expected.pop_front());
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((bar_if.valid && bar_if.ready) || (di_if.valid && di_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      // Drive every input to a known value before the first edge.
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      bar_if.valid = 1'b0;
      bar_if.high_price = '0;
      bar_if.low_price = '0;
      bar_if.close_price = '0;
      bar_if.first_bar = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      gaps_on = 1'b1;
      stall_request = 1'b0;
      walk_base = 64'd6553600;
      walk_spread = 64'd65536;

      cfg_period = pdi_pkg::PERIOD_RESET;
      cfg_unstable = pdi_pkg::UNSTABLE_RESET;
      prev_high = '0;
      prev_low = '0;
      prev_close = '0;
      sum_move = '0;
      sum_range = '0;
      bar_count = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_register(directed_rows[i].csr_index, directed_rows[i].csr_data);
         else
            send_bar(directed_rows[i].bar, directed_rows[i].kind, directed_rows[i].di);
      end

      // Random phases, each under its own register settings.
      for (int p = 0; p < PHASES; p++) begin
         write_register(pdi_pkg::CSR_PERIOD, random_phases[p].period_data);
         write_register(pdi_pkg::CSR_UNSTABLE, random_phases[p].unstable_data);
         gaps_on = random_phases[p].gaps;
         stall_request = random_phases[p].hold;
         // Pick a price level: mid-range, near zero, near the top, or anywhere.
         case ($urandom_range(0, 3))
            0: begin walk_base = 64'd6553600;      walk_spread = 64'd65536; end
            1: begin walk_base = 64'd2000;         walk_spread = 64'd500;   end
            2: begin walk_base = 64'hFFFF_F000;    walk_spread = 64'd4096;  end
            default: begin
               walk_base = longint'($urandom);
               walk_spread = longint'($urandom_range(1, 1 << 20));
            end
         endcase
         repeat (random_phases[p].bars) send_bar(next_bar(), ROW_PREDICT, '0);
      end
      gaps_on = 1'b1;

      // Drain: drop valid, wait for every pending result, then watch for extras.
      bar_if.valid = 1'b0;
      while (di_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && di_expected.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
